@@ rtl/pts_pkg.sv @@
// Package for the periodic task scheduler: codes, defaults, control struct.
// No dependencies; used by pts_cell and periodic_task_scheduler.
package pts_pkg;

   localparam int DEF_MAX_TASKS = 8;
   localparam int DEF_TIME_BITS = 16;

   localparam int IVL_W     = 16;  // interval register width
   localparam int NOW_W     = 32;  // tick counter width
   localparam int CNT_W     = 5;   // sequencer step counter
   localparam int PEND_W    = 8;
   localparam int MISS_LEVEL = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   typedef enum logic [1:0] {
      STRAT_RM  = 2'd0,
      STRAT_EDF = 2'd1,
      STRAT_LLF = 2'd2,
      STRAT_FP  = 2'd3
   } strat_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRATEGY   = 2'd0,
      CSR_INTERVAL   = 2'd1,
      CSR_TASK_COUNT = 2'd2
   } csr_idx_type;

   typedef enum logic {
      CMD_TICK  = 1'b0,
      CMD_WRITE = 1'b1
   } cmd_type;

   // Broadcast from the sequencer to every task cell.
   typedef struct packed {
      logic             update;
      logic             load_key;
      logic             rank_step;
      logic             rank_last;
      logic             mod_clear;
      logic             mod_step;
      logic [CNT_W-1:0] mod_idx;
      logic             commit;
      strat_type        strategy;
      logic [IVL_W-1:0] quantum;
   } ctl_type;

endpackage

@@ rtl/pts_req_if.sv @@
// Request channel: tick or task table write.
// Depends on nothing.
interface pts_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [2:0]  task_index;
   logic [15:0] period_ticks;
   logic [15:0] run_ticks;
   logic [7:0]  prio_level;
   logic        round_robin;

   modport source (output valid, command, task_index, period_ticks, run_ticks,
                   prio_level, round_robin, input ready);
   modport sink   (input valid, command, task_index, period_ticks, run_ticks,
                   prio_level, round_robin, output ready);
endinterface

@@ rtl/pts_rsp_if.sv @@
// Response channel: one scheduling result per tick.
// Depends on nothing.
interface pts_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] now;
   logic        running_valid;
   logic [2:0]  running_id;
   logic        running_changed;
   logic        done_valid;
   logic [2:0]  done_id;
   logic [7:0]  released_mask;
   logic [7:0]  missed_mask;

   modport source (output valid, now, running_valid, running_id, running_changed,
                   done_valid, done_id, released_mask, missed_mask, input ready);
   modport sink   (input valid, now, running_valid, running_id, running_changed,
                   done_valid, done_id, released_mask, missed_mask, output ready);
endinterface

@@ rtl/pts_cell.sv @@
// One task cell: table entry, job state, key, rank counter and ring token.
// Depends on pts_pkg.
module pts_cell import pts_pkg::*; #(
   parameter int MAX_TASKS = DEF_MAX_TASKS,
   parameter int TIME_BITS = DEF_TIME_BITS,
   parameter int IDX       = 0,
   localparam int KW       = TIME_BITS + 2,
   localparam int RW       = $clog2(MAX_TASKS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ctl_type              ctl,
   input  logic                 used_i,
   input  logic                 wr_en_i,
   input  logic [TIME_BITS-1:0] wr_period_i,
   input  logic [TIME_BITS-1:0] wr_runtime_i,
   input  logic [7:0]           wr_prio_i,
   input  logic                 wr_rr_i,
   input  logic signed [KW-1:0] tok_key_i,
   input  logic [RW-1:0]        tok_id_i,
   input  logic                 tok_used_i,
   output logic signed [KW-1:0] tok_key_o,
   output logic [RW-1:0]        tok_id_o,
   output logic                 tok_used_o,
   input  logic                 pick_i,
   output logic [RW-1:0]        rank_o,
   output logic                 elig_o,
   output logic                 last_o,
   output logic                 done_o,
   output logic                 rel_o,
   output logic                 miss_o
);

   localparam logic [RW-1:0]        MY_ID = RW'(IDX);
   localparam logic [TIME_BITS-1:0] T_MAX = '1;

   logic [TIME_BITS-1:0] period_ff, runtime_ff;
   logic [7:0]           prio_ff;
   logic                 rr_ff;
   logic [TIME_BITS-1:0] progress_ff, progress_in;
   logic [TIME_BITS-1:0] until_ff, until_in;
   logic [PEND_W-1:0]    pend_ff, pend_in;
   logic [RW-1:0]        rank_ff, rank_in;
   logic [RW-1:0]        acc_ff, acc_in;
   logic [IVL_W-1:0]     res_ff, res_in;
   logic                 last_ff, last_in;
   logic signed [KW-1:0] key_ff;
   logic signed [KW-1:0] tkey_ff;
   logic [RW-1:0]        tid_ff;
   logic                 tused_ff;

   logic                 done, rel, expired, tok_first, pbit;
   logic [PEND_W-1:0]    pend_dec, pend_rel;
   logic [TIME_BITS:0]   deadline;
   logic signed [KW-1:0] key;
   logic [NOW_W-1:0]     pext;
   logic [IVL_W:0]       r2, rinc;

   assign done     = last_ff & used_i & (progress_ff == runtime_ff);
   assign pend_dec = (done && pend_ff != '0) ? pend_ff - 1'b1 : pend_ff;
   assign rel      = used_i & (until_ff == '0);
   assign pend_rel = (pend_dec == '1) ? pend_dec : pend_dec + 1'b1;

   assign deadline = {1'b0, until_ff} + 1'b1;
   assign expired  = rr_ff & (progress_ff != '0) & (res_ff == '0);

   always_comb begin
      case (ctl.strategy)
         STRAT_RM:  key = KW'(period_ff);
         STRAT_EDF: key = KW'(deadline);
         STRAT_LLF: key = KW'(deadline) - KW'(runtime_ff) + KW'(progress_ff);
         STRAT_FP:  key = KW'({prio_ff, expired});
         default:   key = KW'(period_ff);
      endcase
   end

   always_comb begin
      if (tused_ff != used_i) begin
         tok_first = tused_ff;
      end else if (used_i && tkey_ff != key_ff) begin
         tok_first = tkey_ff < key_ff;
      end else begin
         tok_first = tid_ff < MY_ID;
      end
   end

   assign pext = NOW_W'(progress_ff);
   assign pbit = pext[ctl.mod_idx];
   assign r2   = {res_ff, pbit};
   assign rinc = {1'b0, res_ff} + 1'b1;

   always_comb begin
      progress_in = progress_ff;
      until_in    = until_ff;
      pend_in     = pend_ff;
      rank_in     = rank_ff;
      acc_in      = acc_ff;
      res_in      = res_ff;
      last_in     = last_ff;
      if (ctl.update && used_i) begin
         if (rel) begin
            until_in    = (period_ff != '0) ? period_ff - 1'b1 : '0;
            progress_in = '0;
            res_in      = '0;
            pend_in     = pend_rel;
         end else begin
            until_in = until_ff - 1'b1;
            pend_in  = pend_dec;
         end
      end
      if (ctl.load_key) begin
         acc_in = '0;
      end
      if (ctl.rank_step) begin
         acc_in = acc_ff + RW'(tok_first);
         if (ctl.rank_last) begin
            rank_in = acc_ff + RW'(tok_first);
         end
      end
      if (ctl.mod_clear) begin
         res_in = '0;
      end
      if (ctl.mod_step) begin
         res_in = (r2 >= {1'b0, ctl.quantum}) ? IVL_W'(r2 - {1'b0, ctl.quantum})
                                              : IVL_W'(r2);
      end
      if (ctl.commit) begin
         last_in = pick_i;
         if (pick_i && progress_ff != T_MAX) begin
            progress_in = progress_ff + 1'b1;
            res_in      = (rinc == {1'b0, ctl.quantum}) ? '0 : IVL_W'(rinc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         progress_ff <= '0;
         until_ff    <= '0;
         pend_ff     <= '0;
         rank_ff     <= MY_ID;
         acc_ff      <= '0;
         res_ff      <= '0;
         last_ff     <= 1'b0;
      end else begin
         progress_ff <= progress_in;
         until_ff    <= until_in;
         pend_ff     <= pend_in;
         rank_ff     <= rank_in;
         acc_ff      <= acc_in;
         res_ff      <= res_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en_i) begin
         period_ff  <= wr_period_i;
         runtime_ff <= wr_runtime_i;
         prio_ff    <= wr_prio_i;
         rr_ff      <= wr_rr_i;
      end
      if (ctl.load_key) begin
         key_ff   <= key;
         tkey_ff  <= key;
         tid_ff   <= MY_ID;
         tused_ff <= used_i;
      end else if (ctl.rank_step) begin
         tkey_ff  <= tok_key_i;
         tid_ff   <= tok_id_i;
         tused_ff <= tok_used_i;
      end
   end

   assign tok_key_o  = tkey_ff;
   assign tok_id_o   = tid_ff;
   assign tok_used_o = tused_ff;
   assign rank_o     = rank_ff;
   assign elig_o     = used_i & (pend_ff != '0);
   assign last_o     = last_ff;
   assign done_o     = done;
   assign rel_o      = rel;
   assign miss_o     = rel & (pend_rel >= PEND_W'(MISS_LEVEL));

endmodule

@@ rtl/periodic_task_scheduler.sv @@
// Top level of the periodic task scheduler: sequencer, tick counter, cell row.
// Depends on pts_pkg, pts_req_if, pts_rsp_if, pts_cell.
//
//   channel  dir  handshake        carries
//   req      in   valid/ready      tick or task table write
//   rsp      out  valid/ready      one result per tick
//   csr      in   csr_we only      strategy, interval, task_count
//
// A tick runs update, key, the ring steps of the rank pass, the rank scan
// steps and commit, in that order. The rank pass is skipped on least-laxity
// ticks off the interval.
// After reset, an interval change or a tick counter wrap, the next tick first
// rebuilds the modulo-interval residues bit-serially.
// Reset is synchronous; a stalled result holds the commit of the next tick.
module periodic_task_scheduler import pts_pkg::*; #(
   parameter int MAX_TASKS = DEF_MAX_TASKS,
   parameter int TIME_BITS = DEF_TIME_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   pts_req_if.sink              req,
   pts_rsp_if.source            rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int KW = TIME_BITS + 2;
   localparam int RW = $clog2(MAX_TASKS);

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_MOD  = 7'b0000010,
      S_UPD  = 7'b0000100,
      S_KEY  = 7'b0001000,
      S_RANK = 7'b0010000,
      S_PICK = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   strat_type         strat_ff;
   logic [IVL_W-1:0]  ivl_ff, qsnap_ff, qsnap_in;
   logic [3:0]        tcount_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NOW_W-1:0]  tick_ff, tick_in;
   logic [IVL_W-1:0]  nres_ff, nres_in;
   logic              stale_ff, stale_in;
   logic              found_ff, found_in;
   logic [RW-1:0]     sel_ff, sel_in;
   logic [MAX_TASKS-1:0] done_vec_ff, rel_vec_ff, miss_vec_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_now_ff;
   logic              rsp_rv_ff, rsp_chg_ff, rsp_dv_ff;
   logic [2:0]        rsp_rid_ff, rsp_did_ff;
   logic [7:0]        rsp_rel_ff, rsp_miss_ff;

   logic [IVL_W-1:0]  quantum;
   logic              accept, tick_acc, stale_now, resort, out_go;
   logic [IVL_W:0]    nr2, ninc;
   logic [RW-1:0]     done_id;
   logic              changed;
   ctl_type           ctl;

   logic [MAX_TASKS-1:0] used_vec, elig_vec, last_vec, done_vec, rel_vec, miss_vec;
   logic [MAX_TASKS-1:0] hit_vec, pick_vec, wr_vec;
   logic signed [KW-1:0] tok_key [MAX_TASKS];
   logic [RW-1:0]        tok_id  [MAX_TASKS];
   logic                 tok_used [MAX_TASKS];
   logic [RW-1:0]        rank    [MAX_TASKS];

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         strat_ff  <= STRAT_RM;
         ivl_ff    <= IVL_W'(1);
         tcount_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_STRATEGY:   strat_ff  <= strat_type'(csr_wdata[1:0]);
            CSR_INTERVAL:   ivl_ff    <= csr_wdata;
            CSR_TASK_COUNT: tcount_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign quantum   = (ivl_ff == '0) ? IVL_W'(1) : ivl_ff;
   assign accept    = req.valid & req.ready;
   assign tick_acc  = accept & (req.command == CMD_TICK);
   assign stale_now = stale_ff | (qsnap_ff != quantum);
   assign resort    = (strat_ff != STRAT_LLF) | (nres_ff == '0);
   assign out_go    = (state_ff == S_OUT) & (~rsp_valid_ff | rsp.ready);
   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      for (int i = 0; i < MAX_TASKS; i++) begin
         used_vec[i] = i < int'(tcount_ff);
         hit_vec[i]  = elig_vec[i] & (rank[i] == cnt_ff[RW-1:0]);
         pick_vec[i] = found_ff & (sel_ff == RW'(i));
         wr_vec[i]   = accept & (req.command == CMD_WRITE) & (int'(req.task_index) == i);
      end
   end

   always_comb begin
      sel_in  = sel_ff;
      done_id = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (hit_vec[i]) begin
            sel_in = RW'(i);
         end
         if (done_vec_ff[i]) begin
            done_id = RW'(i);
         end
      end
      if (!(state_ff == S_PICK && !found_ff && hit_vec != '0)) begin
         sel_in = sel_ff;
      end
   end

   assign changed = (pick_vec & ~last_vec) != '0;

   // tick residue: serial remainder and increment
   assign nr2  = {nres_ff, tick_ff[ctl.mod_idx]};
   assign ninc = {1'b0, nres_ff} + 1'b1;

   always_comb begin
      ctl           = '0;
      ctl.strategy  = strat_ff;
      ctl.quantum   = quantum;
      ctl.mod_idx   = CNT_W'(NOW_W - 1) - cnt_ff;
      ctl.mod_clear = tick_acc & stale_now;
      ctl.mod_step  = (state_ff == S_MOD);
      ctl.update    = (state_ff == S_UPD);
      ctl.load_key  = (state_ff == S_KEY);
      ctl.rank_step = (state_ff == S_RANK);
      ctl.rank_last = (state_ff == S_RANK) & (cnt_ff == CNT_W'(MAX_TASKS - 1));
      ctl.commit    = out_go;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      qsnap_in     = qsnap_ff;
      stale_in     = stale_ff;
      nres_in      = nres_ff;
      tick_in      = tick_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      case (state_ff)
         S_IDLE: begin
            if (tick_acc) begin
               cnt_in = '0;
               if (stale_now) begin
                  qsnap_in = quantum;
                  stale_in = 1'b0;
                  nres_in  = '0;
                  state_in = S_MOD;
               end else begin
                  state_in = S_UPD;
               end
            end
         end
         S_MOD: begin
            nres_in = (nr2 >= {1'b0, quantum}) ? IVL_W'(nr2 - {1'b0, quantum})
                                               : IVL_W'(nr2);
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NOW_W - 1)) begin
               state_in = S_UPD;
            end
         end
         S_UPD: begin
            state_in = S_KEY;
         end
         S_KEY: begin
            cnt_in   = '0;
            found_in = 1'b0;
            state_in = resort ? S_RANK : S_PICK;
         end
         S_RANK: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAX_TASKS - 1)) begin
               cnt_in   = '0;
               state_in = S_PICK;
            end
         end
         S_PICK: begin
            if (hit_vec != '0) begin
               found_in = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(MAX_TASKS - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_go) begin
               rsp_valid_in = 1'b1;
               tick_in      = tick_ff + 1'b1;
               nres_in      = (ninc == {1'b0, quantum}) ? '0 : IVL_W'(ninc);
               if (tick_ff == '1) begin
                  stale_in = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         qsnap_ff     <= IVL_W'(1);
         stale_ff     <= 1'b1;
         nres_ff      <= '0;
         tick_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         qsnap_ff     <= qsnap_in;
         stale_ff     <= stale_in;
         nres_ff      <= nres_in;
         tick_ff      <= tick_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in;
      if (state_ff == S_UPD) begin
         done_vec_ff <= done_vec;
         rel_vec_ff  <= rel_vec;
         miss_vec_ff <= miss_vec;
      end
      if (out_go) begin
         rsp_now_ff  <= tick_ff;
         rsp_rv_ff   <= found_ff;
         rsp_rid_ff  <= found_ff ? 3'(sel_ff) : 3'd0;
         rsp_chg_ff  <= changed;
         rsp_dv_ff   <= done_vec_ff != '0;
         rsp_did_ff  <= 3'(done_id);
         rsp_rel_ff  <= 8'(rel_vec_ff);
         rsp_miss_ff <= 8'(miss_vec_ff);
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.now             = rsp_now_ff;
   assign rsp.running_valid   = rsp_rv_ff;
   assign rsp.running_id      = rsp_rid_ff;
   assign rsp.running_changed = rsp_chg_ff;
   assign rsp.done_valid      = rsp_dv_ff;
   assign rsp.done_id         = rsp_did_ff;
   assign rsp.released_mask   = rsp_rel_ff;
   assign rsp.missed_mask     = rsp_miss_ff;

   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
      pts_cell #(
         .MAX_TASKS (MAX_TASKS),
         .TIME_BITS (TIME_BITS),
         .IDX       (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .used_i       (used_vec[g]),
         .wr_en_i      (wr_vec[g]),
         .wr_period_i  (TIME_BITS'(req.period_ticks)),
         .wr_runtime_i (TIME_BITS'(req.run_ticks)),
         .wr_prio_i    (req.prio_level),
         .wr_rr_i      (req.round_robin),
         .tok_key_i    (tok_key[(g + 1) % MAX_TASKS]),
         .tok_id_i     (tok_id[(g + 1) % MAX_TASKS]),
         .tok_used_i   (tok_used[(g + 1) % MAX_TASKS]),
         .tok_key_o    (tok_key[g]),
         .tok_id_o     (tok_id[g]),
         .tok_used_o   (tok_used[g]),
         .pick_i       (pick_vec[g]),
         .rank_o       (rank[g]),
         .elig_o       (elig_vec[g]),
         .last_o       (last_vec[g]),
         .done_o       (done_vec[g]),
         .rel_o        (rel_vec[g]),
         .miss_o       (miss_vec[g])
      );
   end

`ifndef SYNTH
   a_one_last: assert property (@(posedge clock) disable iff (reset)
      $onehot0(last_vec))
      else $error("more than one cell marked as last running");

   a_miss_in_rel: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> ((rsp.missed_mask & ~rsp.released_mask) == 8'd0))
      else $error("missed task not released");

   a_rel_used: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> ((rel_vec_ff & ~used_vec) == '0))
      else $error("release of a task outside task_count");

   a_chg_run: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.running_valid || !rsp.running_changed))
      else $error("change flagged without a running task");

   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      out_go |=> (tick_ff == $past(tick_ff) + 1'b1))
      else $error("tick counter did not advance on commit");
`endif

endmodule
